### sv/dpcm_pkg.sv
// Shared types, constants and a helper function for the daltonize pixel color matrix.
`timescale 1ns / 1ps

package dpcm_pkg;

	// APB register map: two 32-bit registers at byte addresses 0 and 4.
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_MODE      = 1'b0;
	localparam logic REG_INTENSITY = 1'b1;

	localparam logic [1:0] MODE_IDENT = 2'd0;

	localparam logic [6:0] PCT_MAX = 7'd100;
	// t = floor(pct * 65536 / 100) is taken as (pct * T_RECIP) >> T_SHIFT,
	// which is exact for every pct from 0 to 100.
	localparam logic [21:0] T_RECIP = 22'd2684355;
	localparam int T_SHIFT = 12;
	localparam int T_W = 17;
	localparam logic [T_W-1:0] FX_ONE = 17'h10000;

	localparam logic [7:0] CHAN_MAX = 8'd255;

	typedef logic signed [17:0] coef_t;
	typedef coef_t [8:0] coef_mat_t;

	localparam coef_t COEF_ONE = 18'sd65536;

	// Simulation tables for protan, deutan and tritan, row-major.
	localparam logic [15:0] SIM_TAB [3][9] = '{
		'{16'd37160, 16'd28384, 16'd0, 16'd36569, 16'd28966, 16'd0,
		  16'd0, 16'd15859, 16'd49676},
		'{16'd41156, 16'd24379, 16'd0, 16'd45875, 16'd19660, 16'd0,
		  16'd0, 16'd19660, 16'd45875},
		'{16'd62259, 16'd3276, 16'd0, 16'd0, 16'd28384, 16'd37160,
		  16'd0, 16'd31129, 16'd34406}
	};

	function automatic coef_mat_t ident_mat();
		coef_mat_t m;
		for (int i = 0; i < 9; i++) begin
			m[i] = (i % 4 == 0) ? COEF_ONE : '0;
		end
		return m;
	endfunction

endpackage

### sv/dpcm_if.sv
// Valid/ready channel interfaces for input and output pixels.
`timescale 1ns / 1ps

interface dpcm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] alpha_in;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;
	logic       last_in_line;

	modport source (output valid, alpha_in, red_in, green_in, blue_in, last_in_line,
		input ready);
	modport sink (input valid, alpha_in, red_in, green_in, blue_in, last_in_line,
		output ready);
endinterface

interface dpcm_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] alpha_out;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic       last_out;

	modport source (output valid, alpha_out, red_out, green_out, blue_out, last_out,
		input ready);
	modport sink (input valid, alpha_out, red_out, green_out, blue_out, last_out,
		output ready);
endinterface

### sv/dpcm_cfg.sv
// APB configuration registers and coefficient matrix rebuild.
`timescale 1ns / 1ps

module dpcm_cfg import dpcm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output coef_mat_t         coef,
	output logic              busy
);

	localparam logic [1:0] RB_IDLE = 2'd0;
	localparam logic [1:0] RB_T    = 2'd1;
	localparam logic [1:0] RB_COEF = 2'd2;

	logic [1:0]     rb_state_q;
	logic [1:0]     mode_q;
	logic [6:0]     intensity_q;
	logic [T_W-1:0] t_q;
	coef_mat_t      coef_q;

	logic           wr;
	logic           reg_idx;
	logic [6:0]     pct;
	logic [28:0]    t_prod;
	logic [T_W-1:0] t_calc;
	logic [1:0]     sim_sel;
	coef_mat_t      coef_next;

	assign wr      = psel && penable && pwrite;
	assign reg_idx = paddr[2];
	assign pready  = 1'b1;
	assign prdata  = (reg_idx == REG_MODE) ? {30'b0, mode_q} : {25'b0, intensity_q};
	assign coef    = coef_q;
	assign busy    = (rb_state_q != RB_IDLE);

	assign pct     = (intensity_q > PCT_MAX) ? PCT_MAX : intensity_q;
	assign t_prod  = 29'(pct) * 29'(T_RECIP);
	assign t_calc  = t_prod[T_SHIFT +: T_W];
	assign sim_sel = mode_q - 2'd1;

	for (genvar i = 0; i < 9; i++) begin : g_lane
		localparam bit DIAG = (i % 4 == 0);
		logic signed [18:0] c;
		logic signed [36:0] prod;
		logic signed [19:0] base;
		logic signed [19:0] sum;

		always_comb begin
			c    = (DIAG ? 19'sd131072 : 19'sd0) - $signed({3'b0, SIM_TAB[sim_sel][i]});
			prod = c * $signed({20'b0, t_q});
			base = DIAG ? $signed(20'(FX_ONE - t_q)) : 20'sd0;
			// Arithmetic shift gives the floor for negative products.
			sum  = base + 20'(prod >>> 16);
			coef_next[i] = (mode_q == MODE_IDENT) ? COEF_ONE * coef_t'(DIAG) : sum[17:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDENT;
			intensity_q <= '0;
			rb_state_q  <= RB_IDLE;
			coef_q      <= ident_mat();
		end else if (wr) begin
			if (reg_idx == REG_MODE) begin
				mode_q <= pwdata[1:0];
			end else begin
				intensity_q <= pwdata[6:0];
			end
			rb_state_q <= RB_T;
		end else begin
			unique case (rb_state_q)
				RB_T: begin
					rb_state_q <= RB_COEF;
				end
				RB_COEF: begin
					coef_q     <= coef_next;
					rb_state_q <= RB_IDLE;
				end
				default: begin
					rb_state_q <= RB_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rb_state_q == RB_T) begin
			t_q <= t_calc;
		end
	end

endmodule

### sv/dpcm_datapath.sv
// Two-register pixel pipeline: input register, matrix multiply and clamp, result register.
`timescale 1ns / 1ps

module dpcm_datapath import dpcm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  coef_mat_t coef,
	input  logic      hold,
	dpcm_in_if.sink   pix_in,
	dpcm_out_if.source pix_out
);

	logic       v1_q;
	logic       v2_q;
	logic       en1;
	logic       en2;
	logic       take;

	logic [7:0] alpha_s1;
	logic [7:0] red_s1;
	logic [7:0] green_s1;
	logic [7:0] blue_s1;
	logic       last_s1;

	logic [7:0] alpha_s2;
	logic [7:0] red_s2;
	logic [7:0] green_s2;
	logic [7:0] blue_s2;
	logic       last_s2;

	logic [7:0]         ch  [3];
	logic signed [28:0] acc [3];
	logic [7:0]         res [3];

	function automatic logic [7:0] clamp_chan(input logic signed [12:0] q);
		logic [7:0] r;
		priority if (q < 13'sd0) begin
			r = 8'd0;
		end else if (q > $signed({5'b0, CHAN_MAX})) begin
			r = CHAN_MAX;
		end else begin
			r = q[7:0];
		end
		return r;
	endfunction

	// Each stage advances when the one after it is empty or draining.
	assign en2  = !v2_q || pix_out.ready;
	assign en1  = !v1_q || en2;
	assign take = en1 && !hold && pix_in.valid;

	assign pix_in.ready      = en1 && !hold;
	assign pix_out.valid     = v2_q;
	assign pix_out.alpha_out = alpha_s2;
	assign pix_out.red_out   = red_s2;
	assign pix_out.green_out = green_s2;
	assign pix_out.blue_out  = blue_s2;
	assign pix_out.last_out  = last_s2;

	always_comb begin
		ch[0] = red_s1;
		ch[1] = green_s1;
		ch[2] = blue_s1;
		for (int r = 0; r < 3; r++) begin
			acc[r] = '0;
			for (int k = 0; k < 3; k++) begin
				acc[r] = acc[r] + 29'($signed(coef[3 * r + k]) * $signed({1'b0, ch[k]}));
			end
			res[r] = clamp_chan($signed(acc[r][28:16]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (en1) begin
				v1_q <= take;
			end
			if (en2) begin
				v2_q <= v1_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			alpha_s1 <= pix_in.alpha_in;
			red_s1   <= pix_in.red_in;
			green_s1 <= pix_in.green_in;
			blue_s1  <= pix_in.blue_in;
			last_s1  <= pix_in.last_in_line;
		end
		if (en2 && v1_q) begin
			alpha_s2 <= alpha_s1;
			red_s2   <= res[0];
			green_s2 <= res[1];
			blue_s2  <= res[2];
			last_s2  <= last_s1;
		end
	end

endmodule

### sv/daltonize_pixel_color_matrix.sv
// Top level of the daltonize pixel color matrix.
// The block recolors ARGB8888 pixels for color vision deficiency through a 3x3 matrix.
// pix_in takes one pixel beat (alpha, red, green, blue, line-end mark) per cycle on
// valid/ready; pix_out delivers the corrected beat with alpha and the mark unchanged.
// A pixel is registered on entry, multiplied by the matrix and clamped, then held in
// the result register until taken. Throughput is one pixel per cycle, set by the
// single pass of nine multipliers between those two registers, while pix_out is ready
// and no rebuild runs. When the receiver stalls, the result register holds and the
// input register still fills, so one more beat is taken before pix_in.ready drops.
// The APB port writes mode (address 0) and intensity (address 4). After each write
// the matrix is rebuilt, during which pix_in.ready is low.
// After reset mode and intensity are zero, the matrix is the identity and both
// pipeline registers are empty.
`timescale 1ns / 1ps

module daltonize_pixel_color_matrix import dpcm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	dpcm_in_if.sink           pix_in,
	dpcm_out_if.source        pix_out
);

	coef_mat_t coef;
	logic      busy;

	dpcm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coef    (coef),
		.busy    (busy)
	);

	dpcm_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.coef    (coef),
		.hold    (busy),
		.pix_in  (pix_in),
		.pix_out (pix_out)
	);

endmodule

### bench/tb_daltonize_pixel_color_matrix.sv
// Self-checking testbench for the daltonize pixel color matrix: APB setup, pixel traffic, checks.
`timescale 1ns / 1ps

module tb_daltonize_pixel_color_matrix;
	import dpcm_pkg::*;

	localparam logic [1:0] MODE_PROTAN = 2'd1;
	localparam logic [1:0] MODE_DEUTAN = 2'd2;
	localparam logic [1:0] MODE_TRITAN = 2'd3;

	localparam int SEGMENTS    = 7;
	localparam int SEG_PIXELS  = 250;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 4;
	localparam longint FX_UNIT = 65536;

	// Color blindness simulation matrices in 16.16, row-major: protan, deutan, tritan.
	localparam longint CVD_SIM [3][9] = '{
		'{37160, 28384, 0, 36569, 28966, 0, 0, 15859, 49676},
		'{41156, 24379, 0, 45875, 19660, 0, 0, 19660, 45875},
		'{62259, 3276, 0, 0, 28384, 37160, 0, 31129, 34406}
	};

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       line_end;
	} argb_pixel_t;

	class pixel_matrix_scoreboard;
		logic [1:0]  mode_reg;
		logic [6:0]  intensity_reg;
		longint      coef[9];
		argb_pixel_t pending[$];
		int          mismatches;

		function new();
			mode_reg = MODE_IDENT;
			intensity_reg = '0;
			mismatches = 0;
			load_identity();
		endfunction

		function void load_identity();
			for (int i = 0; i < 9; i++) begin
				coef[i] = (i % 4 == 0) ? FX_UNIT : 0;
			end
		endfunction

		// Every register write rebuilds the whole matrix from mode and intensity.
		function void write_reg(logic reg_sel, logic [DATA_W-1:0] value);
			longint pct;
			longint t;
			longint diag;
			longint target;
			if (reg_sel == REG_MODE) begin
				mode_reg = value[1:0];
			end else begin
				intensity_reg = value[6:0];
			end
			if (mode_reg == MODE_IDENT) begin
				load_identity();
				return;
			end
			pct = (intensity_reg > PCT_MAX) ? 100 : longint'(intensity_reg);
			t = (pct * FX_UNIT) / 100;
			for (int i = 0; i < 9; i++) begin
				diag = (i % 4 == 0) ? FX_UNIT : 0;
				target = 2 * diag - CVD_SIM[mode_reg - 2'd1][i];
				// Arithmetic shift of a signed product rounds toward minus infinity.
				coef[i] = ((i % 4 == 0) ? (FX_UNIT - t) : 0) + ((target * t) >>> 16);
			end
		endfunction

		function void note_pixel(argb_pixel_t px);
			argb_pixel_t exp_px;
			longint chan[3];
			longint res[3];
			longint acc;
			chan[0] = px.red;
			chan[1] = px.green;
			chan[2] = px.blue;
			for (int row = 0; row < 3; row++) begin
				acc = 0;
				for (int k = 0; k < 3; k++) begin
					acc += coef[row * 3 + k] * chan[k];
				end
				acc = acc >>> 16;
				res[row] = (acc < 0) ? 0 : ((acc > 255) ? 255 : acc);
			end
			exp_px = px;
			exp_px.red = res[0][7:0];
			exp_px.green = res[1][7:0];
			exp_px.blue = res[2][7:0];
			pending.push_back(exp_px);
		endfunction

		function void check_pixel(argb_pixel_t got);
			argb_pixel_t exp_px;
			if (pending.size() == 0) begin
				$error("output pixel with none expected: a=%0d r=%0d g=%0d b=%0d last=%0d",
					got.alpha, got.red, got.green, got.blue, got.line_end);
				mismatches++;
				return;
			end
			exp_px = pending.pop_front();
			if (got.alpha !== exp_px.alpha) begin
				$error("alpha_out: expected %0d, got %0d", exp_px.alpha, got.alpha);
				mismatches++;
			end
			if (got.red !== exp_px.red) begin
				$error("red_out: expected %0d, got %0d", exp_px.red, got.red);
				mismatches++;
			end
			if (got.green !== exp_px.green) begin
				$error("green_out: expected %0d, got %0d", exp_px.green, got.green);
				mismatches++;
			end
			if (got.blue !== exp_px.blue) begin
				$error("blue_out: expected %0d, got %0d", exp_px.blue, got.blue);
				mismatches++;
			end
			if (got.line_end !== exp_px.line_end) begin
				$error("last_out: expected %0d, got %0d", exp_px.line_end, got.line_end);
				mismatches++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	dpcm_in_if  pix_in_bus();
	dpcm_out_if pix_out_bus();

	daltonize_pixel_color_matrix i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pix_in  (pix_in_bus),
		.pix_out (pix_out_bus)
	);

	pixel_matrix_scoreboard color_sb;
	int tx_gap_pct   = 0;
	int rx_stall_pct = 0;
	int tx_calm      = 0;
	int rx_calm      = 0;
	int cycle_count  = 0;

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && pix_out_bus.valid && pix_out_bus.ready) begin
			color_sb.check_pixel({pix_out_bus.alpha_out, pix_out_bus.red_out,
				pix_out_bus.green_out, pix_out_bus.blue_out, pix_out_bus.last_out});
		end
	end

	// Output backpressure, with occasional stretches of steady readiness.
	initial begin
		pix_out_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_calm > 0) begin
				rx_calm--;
				pix_out_bus.ready <= 1'b1;
			end else begin
				if ($urandom_range(99) < 4) begin
					rx_calm = $urandom_range(40, 8);
				end
				pix_out_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	task automatic send_pixel(argb_pixel_t px);
		if (tx_calm > 0) begin
			tx_calm--;
		end else if ($urandom_range(99) < 4) begin
			tx_calm = $urandom_range(30, 8);
		end
		while (tx_calm == 0 && $urandom_range(99) < tx_gap_pct) begin
			pix_in_bus.valid <= 1'b0;
			@(posedge clk);
		end
		pix_in_bus.valid <= 1'b1;
		pix_in_bus.alpha_in <= px.alpha;
		pix_in_bus.red_in <= px.red;
		pix_in_bus.green_in <= px.green;
		pix_in_bus.blue_in <= px.blue;
		pix_in_bus.last_in_line <= px.line_end;
		do @(posedge clk); while (!pix_in_bus.ready);
		color_sb.note_pixel(px);
	endtask

	task automatic stop_pixels();
		pix_in_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (color_sb.pending.size() != 0) @(posedge clk);
	endtask

	task automatic apb_write(logic reg_sel, logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		color_sb.write_reg(reg_sel, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_check(logic reg_sel, logic [DATA_W-1:0] exp_value, string reg_name);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {reg_sel, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== exp_value) begin
			$error("%s: expected %0d, got %0d", reg_name, exp_value, prdata);
			color_sb.mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Only called with no pixel in flight; upper data bits are sometimes junk.
	task automatic set_correction(logic [1:0] mode_val, logic [6:0] pct_val);
		logic [DATA_W-1:0] mode_word;
		logic [DATA_W-1:0] pct_word;
		mode_word = {30'(($urandom_range(1) == 1) ? $urandom() : 0), mode_val};
		pct_word = {25'(($urandom_range(1) == 1) ? $urandom() : 0), pct_val};
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if ($urandom_range(1) == 1) begin
			apb_write(REG_MODE, mode_word);
			apb_write(REG_INTENSITY, pct_word);
		end else begin
			apb_write(REG_INTENSITY, pct_word);
			apb_write(REG_MODE, mode_word);
		end
		apb_check(REG_MODE, DATA_W'(mode_val), "mode");
		apb_check(REG_INTENSITY, DATA_W'(pct_val), "intensity");
	endtask

	function automatic logic [7:0] biased_level();
		case ($urandom_range(2))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom());
		endcase
	endfunction

	function automatic argb_pixel_t random_pixel();
		argb_pixel_t px;
		px = argb_pixel_t'($urandom());
		px.alpha = 8'($urandom());
		px.line_end = ($urandom_range(3) == 0);
		// Saturated channels drive the clamps at both ends.
		if ($urandom_range(9) < 3) begin
			px.red = biased_level();
			px.green = biased_level();
			px.blue = biased_level();
		end
		return px;
	endfunction

	initial begin
		argb_pixel_t probe_pixels[6];
		logic [1:0]  seg_mode;
		logic [6:0]  seg_pct;

		color_sb = new();
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pix_in_bus.valid <= 1'b0;
		pix_in_bus.alpha_in <= '0;
		pix_in_bus.red_in <= '0;
		pix_in_bus.green_in <= '0;
		pix_in_bus.blue_in <= '0;
		pix_in_bus.last_in_line <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_check(REG_MODE, '0, "mode");
		apb_check(REG_INTENSITY, '0, "intensity");

		probe_pixels = '{
			'{8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
			'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1},
			'{8'hA5, 8'hFF, 8'h00, 8'h00, 1'b0},
			'{8'h5A, 8'h00, 8'hFF, 8'h00, 1'b1},
			'{8'h0F, 8'h00, 8'h00, 8'hFF, 1'b0},
			'{8'hF0, 8'h80, 8'h40, 8'hC0, 1'b1}
		};
		tx_gap_pct = 28;
		rx_stall_pct = 81;

		// Reset identity, full protan, saturated tritan, half deutan.
		for (int cfg = 0; cfg < 4; cfg++) begin
			case (cfg)
				1: set_correction(MODE_PROTAN, 7'd100);
				2: set_correction(MODE_TRITAN, 7'd127);
				3: set_correction(MODE_DEUTAN, 7'd50);
				default: ;
			endcase
			foreach (probe_pixels[i]) send_pixel(probe_pixels[i]);
			stop_pixels();
		end

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0: begin seg_mode = MODE_PROTAN; seg_pct = 7'($urandom_range(99, 1)); end
				1: begin seg_mode = MODE_DEUTAN; seg_pct = 7'd100; end
				2: begin seg_mode = MODE_TRITAN; seg_pct = 7'd0; end
				3: begin seg_mode = MODE_IDENT; seg_pct = 7'd100; end
				4: begin
					seg_mode = 2'($urandom_range(3, 1));
					seg_pct = 7'($urandom_range(127, 101));
				end
				5: begin seg_mode = 2'($urandom()); seg_pct = 7'($urandom()); end
				default: begin seg_mode = MODE_TRITAN; seg_pct = 7'd1; end
			endcase
			set_correction(seg_mode, seg_pct);
			tx_gap_pct = (seg < 2) ? 28 : ((seg < 4) ? 81 : 0);
			rx_stall_pct = (seg < 2) ? 81 : ((seg < 4) ? 28 : 0);
			for (int n = 0; n < SEG_PIXELS; n++) begin
				// Let the pipeline run dry once in the middle of the stream.
				if (seg == 3 && n == SEG_PIXELS / 2) begin
					stop_pixels();
					wait_drained();
				end
				send_pixel(random_pixel());
			end
			stop_pixels();
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (color_sb.pending.size() != 0) begin
			$error("%0d expected output pixels never arrived", color_sb.pending.size());
			color_sb.mismatches++;
		end
		if (color_sb.mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
sv/dpcm_pkg.sv
sv/dpcm_if.sv
sv/dpcm_cfg.sv
sv/dpcm_datapath.sv
sv/daltonize_pixel_color_matrix.sv
bench/tb_daltonize_pixel_color_matrix.sv
